@@ rtl/core/bce_pkg.sv @@
// Package: types, constants and lookup tables for the battery charge estimator.
`timescale 1ns / 1ps

package bce_pkg;

  localparam int FRAC_BITS     = 8;
  localparam int MV_W          = 20;
  localparam int FILT_W        = MV_W + FRAC_BITS;
  localparam int PIN_W         = 12;
  localparam int GAIN_W        = 16;
  localparam int PROD_W        = PIN_W + GAIN_W;
  localparam int DIV_W         = FILT_W + 4;
  localparam int CNT_W         = $clog2(DIV_W);
  localparam int PCT_W         = 7;
  localparam int TABLE_ENTRIES = 101;
  localparam int SRCH_STEPS    = 5;
  localparam int CFG_W         = 16;
  localparam int CFG_ADDR_W    = 2;

  localparam logic [12:0] SOC_FULL_MV  = 13'd4200;
  localparam logic [12:0] SOC_EMPTY_MV = 13'd3200;
  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY  = 7'd0;
  localparam logic [PCT_W-1:0] IDX_START  = 7'd50;
  localparam logic [MV_W-1:0]  MV_MAX     = {MV_W{1'b1}};

  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIVIDER_GAIN  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CELL_COUNT    = 2'd2;

  typedef struct packed {
    logic [31:0]      now_ms;
    logic [PIN_W-1:0] pin_mv;
  } in_req_t;

  typedef struct packed {
    logic [MV_W-1:0]  pack_mv;
    logic [MV_W-1:0]  filtered_mv;
    logic [PCT_W-1:0] charge_percent;
  } out_res_t;

  localparam logic [12:0] SOC_TABLE [TABLE_ENTRIES] = '{
    13'd3200,
    13'd3250, 13'd3300, 13'd3350, 13'd3400, 13'd3450, 13'd3500, 13'd3550, 13'd3600,
    13'd3650, 13'd3700, 13'd3703, 13'd3706, 13'd3710, 13'd3713, 13'd3716,
    13'd3719, 13'd3723, 13'd3726, 13'd3729, 13'd3732, 13'd3735, 13'd3739, 13'd3742,
    13'd3745, 13'd3748, 13'd3752, 13'd3755, 13'd3758, 13'd3761, 13'd3765,
    13'd3768, 13'd3771, 13'd3774, 13'd3777, 13'd3781, 13'd3784, 13'd3787, 13'd3790,
    13'd3794, 13'd3797, 13'd3800, 13'd3805, 13'd3811, 13'd3816, 13'd3821,
    13'd3826, 13'd3832, 13'd3837, 13'd3842, 13'd3847, 13'd3853, 13'd3858, 13'd3863,
    13'd3868, 13'd3874, 13'd3879, 13'd3884, 13'd3889, 13'd3895, 13'd3900,
    13'd3906, 13'd3911, 13'd3917, 13'd3922, 13'd3928, 13'd3933, 13'd3939, 13'd3944,
    13'd3950, 13'd3956, 13'd3961, 13'd3967, 13'd3972, 13'd3978, 13'd3983,
    13'd3989, 13'd3994, 13'd4000, 13'd4008, 13'd4015, 13'd4023, 13'd4031, 13'd4038,
    13'd4046, 13'd4054, 13'd4062, 13'd4069, 13'd4077, 13'd4085, 13'd4092,
    13'd4100, 13'd4111, 13'd4122, 13'd4133, 13'd4144, 13'd4156, 13'd4167, 13'd4178,
    13'd4189, 13'd4200
  };

  function automatic logic [12:0] soc_entry(input logic [PCT_W-1:0] idx);
    if (idx < PCT_W'(TABLE_ENTRIES)) begin
      return SOC_TABLE[idx];
    end
    return SOC_FULL_MV;
  endfunction

  function automatic logic [PCT_W-1:0] search_step(input logic [CNT_W-1:0] k);
    logic [PCT_W-1:0] s;
    case (k)
      5'd0: s = 7'd25;
      5'd1: s = 7'd12;
      5'd2: s = 7'd6;
      5'd3: s = 7'd3;
      5'd4: s = 7'd1;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/battery_charge_estimator.sv @@
// Top level: bit-serial state-of-charge estimator with filter and table search.
`timescale 1ns / 1ps

// Each accepted request whose timestamp is at least sample_period_ms past the
// last kept one produces one result; a request that comes too early is
// accepted and dropped. A kept request runs through a 12-step shift-add
// multiplier, a 32-step restoring divider by ten for the filter, the same
// divider for 32 steps by the cell count, and up to five table search steps.
// The divide by ten is skipped when the filter loads the sample directly
// (filter at zero), and the search is skipped when the per-cell voltage is at
// or beyond the table ends. A finished result sits in an output register, so
// a new request is taken while it waits. The user must write configuration
// through cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block
// itself does not enforce this.
module battery_charge_estimator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bce_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bce_pkg::out_res_t             out_res,
  input  logic                          cfg_we,
  input  logic [bce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bce_pkg::CFG_W-1:0]      cfg_wdata
);
  import bce_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_LOAD  = 9'b000000100,
    S_DIV10 = 9'b000001000,
    S_PREP  = 9'b000010000,
    S_DIVC  = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_SRCH  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [15:0]         period_r, period_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [3:0]          cells_r, cells_nxt;
  logic [FILT_W-1:0]   filt_r, filt_nxt;
  logic [31:0]         last_r, last_nxt;
  logic [PIN_W-1:0]    pin_sh_r, pin_sh_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [MV_W-1:0]     pack_r, pack_nxt;
  logic [DIV_W-1:0]    q_r, q_nxt;
  logic [3:0]          rem_r, rem_nxt;
  logic [3:0]          dvs_r, dvs_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PCT_W-1:0]    idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_res_t            out_res_r, out_res_nxt;

  logic [31:0]         elapsed;
  logic                due;
  logic [4:0]          div_t;
  logic                div_ge;
  logic [PROD_W-1:0]   prod_step;
  logic [FILT_W-1:0]   sample;
  logic [DIV_W-1:0]    blend;
  logic [FILT_W-1:0]   cell_q;
  logic [FILT_W-1:0]   entry_q;
  logic                take_out;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign elapsed   = in_req.now_ms - last_r;
  assign due       = (elapsed >= {16'd0, period_r});
  assign prod_step = {prod_r[PROD_W-2:0], 1'b0}
                   + (pin_sh_r[PIN_W-1] ? PROD_W'(gain_r) : PROD_W'(0));
  assign sample    = {pack_r, {FRAC_BITS{1'b0}}};
  assign blend     = (DIV_W'(filt_r) << 3) + DIV_W'(filt_r) + DIV_W'(sample);
  assign div_t     = {rem_r, q_r[DIV_W-1]};
  assign div_ge    = (div_t >= {1'b0, dvs_r});
  assign cell_q    = q_r[FILT_W-1:0];
  assign entry_q   = FILT_W'(soc_entry(idx_r)) << FRAC_BITS;
  assign take_out  = out_valid_r && out_ready;

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    gain_nxt      = gain_r;
    cells_nxt     = cells_r;
    filt_nxt      = filt_r;
    last_nxt      = last_r;
    pin_sh_nxt    = pin_sh_r;
    prod_nxt      = prod_r;
    pack_nxt      = pack_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !take_out;
    out_res_nxt   = out_res_r;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_SAMPLE_PERIOD: period_nxt = cfg_wdata;
        CFG_DIVIDER_GAIN:  gain_nxt   = cfg_wdata;
        CFG_CELL_COUNT:    cells_nxt  = cfg_wdata[3:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && due) begin
          last_nxt   = in_req.now_ms;
          pin_sh_nxt = in_req.pin_mv;
          prod_nxt   = '0;
          cnt_nxt    = '0;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt   = prod_step;
        pin_sh_nxt = {pin_sh_r[PIN_W-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PIN_W - 1)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        pack_nxt = (prod_r[PROD_W-1:8] > PROD_W'(MV_MAX) ? MV_MAX : prod_r[MV_W+7:8]);
        state_nxt = S_LOAD;
        if (pack_r == pack_nxt && cnt_r == '0) begin
          if (filt_r == '0) begin
            filt_nxt  = sample;
            state_nxt = S_PREP;
          end else begin
            q_nxt     = blend;
            rem_nxt   = '0;
            dvs_nxt   = 4'd10;
            state_nxt = S_DIV10;
          end
        end
        cnt_nxt = '0;
      end
      S_DIV10: begin
        rem_nxt = div_ge ? 4'(div_t - {1'b0, dvs_r}) : div_t[3:0];
        q_nxt   = {q_r[DIV_W-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          filt_nxt  = q_nxt[FILT_W-1:0];
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        q_nxt     = DIV_W'(filt_r);
        rem_nxt   = '0;
        dvs_nxt   = (cells_r == 4'd0) ? 4'd1 : cells_r;
        cnt_nxt   = '0;
        state_nxt = S_DIVC;
      end
      S_DIVC: begin
        rem_nxt = div_ge ? 4'(div_t - {1'b0, dvs_r}) : div_t[3:0];
        q_nxt   = {q_r[DIV_W-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (cell_q >= (FILT_W'(SOC_FULL_MV) << FRAC_BITS)) begin
          idx_nxt   = PCT_FULL;
          state_nxt = S_DONE;
        end else if (cell_q <= (FILT_W'(SOC_EMPTY_MV) << FRAC_BITS)) begin
          idx_nxt   = PCT_EMPTY;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = IDX_START;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        idx_nxt = (cell_q >= entry_q) ? idx_r + search_step(cnt_r)
                                      : idx_r - search_step(cnt_r);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SRCH_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_res_nxt.pack_mv        = pack_r;
          out_res_nxt.filtered_mv    = filt_r[FILT_W-1:FRAC_BITS];
          out_res_nxt.charge_percent = idx_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= 16'd1000;
      gain_r      <= 16'd1024;
      cells_r     <= 4'd1;
      filt_r      <= '0;
      last_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      gain_r      <= gain_nxt;
      cells_r     <= cells_nxt;
      filt_r      <= filt_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pin_sh_r  <= pin_sh_nxt;
    prod_r    <= prod_nxt;
    pack_r    <= pack_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    idx_r     <= idx_nxt;
    out_res_r <= out_res_nxt;
  end

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.charge_percent <= PCT_FULL))
    else $error("charge percent out of range");

  a_early_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && !due) |=> (state_r == S_IDLE))
    else $error("early request not dropped");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r < CNT_W'(PIN_W)))
    else $error("multiplier step count overrun");

endmodule

@@ bench/tb_battery_charge_estimator.sv @@
`timescale 1ns / 1ps
// Testbench: directed and random self-checking run of the battery charge estimator.
module tb_battery_charge_estimator;
  import bce_pkg::*;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 1500;
  localparam int PHASE_REQS    = 130;
  localparam int ACC_W         = FILT_W + 5;
  localparam int CELL_FULL_MV  = 4200;
  localparam int CELL_EMPTY_MV = 3200;

  typedef enum logic [1:0] {NO_IDLE, SEND_IDLE, RECV_STALL, BOTH_IDLE} idle_mode_e;

  localparam logic [12:0] OCV_MV [101] = '{
    13'd3200,
    13'd3250, 13'd3300, 13'd3350, 13'd3400, 13'd3450, 13'd3500, 13'd3550, 13'd3600,
    13'd3650, 13'd3700, 13'd3703, 13'd3706, 13'd3710, 13'd3713, 13'd3716,
    13'd3719, 13'd3723, 13'd3726, 13'd3729, 13'd3732, 13'd3735, 13'd3739, 13'd3742,
    13'd3745, 13'd3748, 13'd3752, 13'd3755, 13'd3758, 13'd3761, 13'd3765,
    13'd3768, 13'd3771, 13'd3774, 13'd3777, 13'd3781, 13'd3784, 13'd3787, 13'd3790,
    13'd3794, 13'd3797, 13'd3800, 13'd3805, 13'd3811, 13'd3816, 13'd3821,
    13'd3826, 13'd3832, 13'd3837, 13'd3842, 13'd3847, 13'd3853, 13'd3858, 13'd3863,
    13'd3868, 13'd3874, 13'd3879, 13'd3884, 13'd3889, 13'd3895, 13'd3900,
    13'd3906, 13'd3911, 13'd3917, 13'd3922, 13'd3928, 13'd3933, 13'd3939, 13'd3944,
    13'd3950, 13'd3956, 13'd3961, 13'd3967, 13'd3972, 13'd3978, 13'd3983,
    13'd3989, 13'd3994, 13'd4000, 13'd4008, 13'd4015, 13'd4023, 13'd4031, 13'd4038,
    13'd4046, 13'd4054, 13'd4062, 13'd4069, 13'd4077, 13'd4085, 13'd4092,
    13'd4100, 13'd4111, 13'd4122, 13'd4133, 13'd4144, 13'd4156, 13'd4167, 13'd4178,
    13'd4189, 13'd4200
  };

  localparam logic [PCT_W-1:0] HALVING [5] = '{7'd25, 7'd12, 7'd6, 7'd3, 7'd1};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_req_t               in_req    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_res_t              out_res;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  logic [15:0]       period_reg   = 16'd1000;
  logic [15:0]       gain_reg     = 16'd1024;
  logic [3:0]        cells_reg    = 4'd1;
  logic [FILT_W-1:0] filt_q       = '0;
  logic [31:0]       last_kept_ms = '0;

  in_req_t     pending_reqs[$];
  out_res_t    expected_results[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        holding        = 1'b0;
  bit          hold_go        = 1'b0;
  logic [31:0] gen_stamp      = '0;
  int          gen_target_mv  = 3700;
  int unsigned cycle_count    = 0;

  battery_charge_estimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit estimate_charge(input in_req_t req, output out_res_t res);
    logic [31:0]        since;
    logic [PROD_W-1:0]  prod;
    logic [MV_W-1:0]    pack;
    logic [ACC_W-1:0]   next_q;
    logic [FILT_W-1:0]  per_cell;
    logic [3:0]         cells;
    logic [PCT_W-1:0]   idx;
    res = '0;
    since = req.now_ms - last_kept_ms;
    if (since < 32'(period_reg)) return 1'b0;
    last_kept_ms = req.now_ms;
    prod = (PROD_W'(req.pin_mv) * PROD_W'(gain_reg)) >> 8;
    pack = (prod > PROD_W'({MV_W{1'b1}})) ? {MV_W{1'b1}} : prod[MV_W-1:0];
    if (filt_q == '0) begin
      next_q = ACC_W'(pack) << FRAC_BITS;
    end else begin
      next_q = (ACC_W'(9) * ACC_W'(filt_q) + (ACC_W'(pack) << FRAC_BITS)) / ACC_W'(10);
    end
    if (next_q > ACC_W'({FILT_W{1'b1}})) next_q = ACC_W'({FILT_W{1'b1}});
    filt_q = next_q[FILT_W-1:0];
    cells = (cells_reg == 4'd0) ? 4'd1 : cells_reg;
    per_cell = filt_q / FILT_W'(cells);
    if (per_cell >= (FILT_W'(CELL_FULL_MV) << FRAC_BITS)) begin
      idx = 7'd100;
    end else if (per_cell <= (FILT_W'(CELL_EMPTY_MV) << FRAC_BITS)) begin
      idx = 7'd0;
    end else begin
      idx = 7'd50;
      for (int k = 0; k < 5; k++) begin
        if (per_cell >= (FILT_W'(OCV_MV[idx]) << FRAC_BITS)) idx = idx + HALVING[k];
        else idx = idx - HALVING[k];
      end
    end
    res.pack_mv        = pack;
    res.filtered_mv    = filt_q[FILT_W-1:FRAC_BITS];
    res.charge_percent = idx;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [MV_W-1:0] want,
                                      input logic [MV_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_req   <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : receiver_hold
    wait (hold_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin : monitor
    out_res_t predicted;
    out_res_t oldest;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (estimate_charge(in_req, predicted)) expected_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: pack %0d filtered %0d percent %0d",
                   $time, out_res.pack_mv, out_res.filtered_mv, out_res.charge_percent);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("pack_mv", oldest.pack_mv, out_res.pack_mv);
          check_field("filtered_mv", oldest.filtered_mv, out_res.filtered_mv);
          check_field("charge_percent", MV_W'(oldest.charge_percent),
                      MV_W'(out_res.charge_percent));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_regs(input logic [15:0] period, input logic [15:0] gain,
                            input logic [15:0] cells_word);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SAMPLE_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_addr  <= CFG_DIVIDER_GAIN;
    cfg_wdata <= gain;
    @(posedge clk);
    cfg_addr  <= CFG_CELL_COUNT;
    cfg_wdata <= cells_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    period_reg = period;
    gain_reg   = gain;
    cells_reg  = cells_word[3:0];
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      NO_IDLE: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
      end
      SEND_IDLE: begin
        send_idle_pct  <= 78;
        recv_stall_pct <= 0;
      end
      RECV_STALL: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 78;
      end
      default: begin
        send_idle_pct  <= 23;
        recv_stall_pct <= 23;
      end
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_req(input logic [31:0] now, input logic [PIN_W-1:0] pin);
    in_req_t req;
    req.now_ms = now;
    req.pin_mv = pin;
    gen_stamp  = now;
    pending_reqs.push_back(req);
  endtask

  task automatic queue_zero_run(input int count);
    repeat (count) queue_req(gen_stamp + period_reg + $urandom_range(5), '0);
  endtask

  task automatic queue_random_reqs(input int wanted);
    int          kept;
    int          cells;
    int          roll;
    int          pin;
    logic [31:0] step;
    kept  = 0;
    cells = (cells_reg == 4'd0) ? 1 : int'(cells_reg);
    while (kept < wanted) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        step = period_reg + $urandom_range(40);
        kept++;
      end else if (roll < 92) begin
        step = $urandom_range(period_reg);
      end else if (roll < 96) begin
        step = '0;
      end else begin
        step = $urandom();
      end
      gen_target_mv = gen_target_mv + int'($urandom_range(60)) - 30;
      if ($urandom_range(49) == 0) gen_target_mv = 3100 + int'($urandom_range(1200));
      if (gen_target_mv < 3100) gen_target_mv = 3100;
      if (gen_target_mv > 4300) gen_target_mv = 4300;
      if (gain_reg == '0 || $urandom_range(99) < 8) begin
        pin = int'($urandom_range(4095));
      end else begin
        pin = (gen_target_mv * cells * 256) / int'(gain_reg);
        if (pin > 4095) pin = 4095;
      end
      queue_req(gen_stamp + step, PIN_W'(pin));
    end
  endtask

  function automatic logic [15:0] pick_gain(input logic [15:0] cells_word);
    int cells;
    cells = (cells_word[3:0] == 4'd0) ? 1 : int'(cells_word[3:0]);
    return 16'((4300 * cells * 256) / int'($urandom_range(4000, 1200)));
  endfunction

  task automatic run_phase(input idle_mode_e mode, input logic [15:0] period,
                           input logic [15:0] cells_word, input logic [15:0] gain,
                           input bit hold);
    write_regs(period, gain, cells_word);
    set_idling(mode);
    if (hold) hold_go = 1'b1;
    queue_random_reqs(PHASE_REQS);
    drain();
  endtask

  initial begin : stimulus
    logic [15:0] cells_word;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    queue_req(32'd0, 12'd900);
    queue_req(32'd999, 12'd900);
    queue_req(32'd1000, 12'd900);
    queue_req(32'd2000, 12'hFFF);
    queue_req(32'd3000, 12'd0);
    queue_req(32'hFFFF_FC18, 12'd1050);
    queue_req(32'h0000_0000, 12'd800);
    queue_req(32'h0000_03E7, 12'd800);
    queue_req(32'hFFFF_FFFF, 12'hFFF);
    drain();

    write_regs(16'd0, 16'd0, 16'd0);
    queue_req(32'hFFFF_FFFF, 12'hFFF);
    queue_req(32'd0, 12'd0);
    queue_req(32'd0, 12'hAAA);
    drain();

    write_regs(16'hFFFF, 16'hFFFF, 16'd15);
    queue_req(32'd65534, 12'hFFF);
    queue_req(32'd65535, 12'hFFF);
    queue_req(32'd131070, 12'h555);
    queue_req(32'd131071, 12'd1);
    drain();

    cells_word = 16'($urandom_range(8, 1));
    run_phase(NO_IDLE, 16'($urandom_range(2000, 1)), cells_word, pick_gain(cells_word), 1'b0);
    cells_word = 16'($urandom_range(8, 1));
    run_phase(SEND_IDLE, 16'($urandom_range(2000, 1)), cells_word, pick_gain(cells_word), 1'b0);
    cells_word = 16'($urandom_range(8, 1));
    run_phase(RECV_STALL, 16'($urandom_range(2000, 1)), cells_word, pick_gain(cells_word), 1'b1);
    cells_word = 16'($urandom_range(8, 1));
    run_phase(BOTH_IDLE, 16'($urandom_range(2000, 1)), cells_word, pick_gain(cells_word), 1'b0);

    // decay the filter to zero, then reload it at both table ends
    write_regs(16'd0, 16'd1024, 16'hFFF0);
    set_idling(NO_IDLE);
    queue_zero_run(200);
    queue_req(gen_stamp + 1, 12'd800);
    queue_zero_run(200);
    queue_req(gen_stamp + 1, 12'd1050);
    queue_random_reqs(60);
    drain();

    run_phase(SEND_IDLE, 16'hFFFF, 16'd9, 16'hFFFF, 1'b0);
    cells_word = 16'($urandom_range(15, 9));
    run_phase(RECV_STALL, 16'($urandom_range(100, 0)), cells_word, pick_gain(cells_word), 1'b0);
    cells_word = 16'($urandom_range(8, 1));
    run_phase(BOTH_IDLE, 16'($urandom_range(5000, 1)), cells_word, pick_gain(cells_word), 1'b0);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
